>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module mlcs_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define MLCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define MLCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mlcs_pkg.sv
// ---------------------------------------------------------------------------
// mlcs_pkg
// Types, register indexes and constants of the min-max contrast stretch.
// ---------------------------------------------------------------------------
package mlcs_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned PIXEL_W    = 16;
    localparam int unsigned RANGE_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned MIDQ_DEPTH = 2;
    localparam int unsigned OUTQ_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITS_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH    = 3'd5;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_SCALE   = 1'b1;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] MODE_8_OFS  = 2'd0;
    localparam logic [1:0] MODE_8      = 2'd1;
    localparam logic [1:0] MODE_16_OFS = 2'd2;
    localparam logic [1:0] MODE_16     = 2'd3;

    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] sample;
        logic                     sample_void;
        logic                     frame_last;
    } t_in_item;

    typedef struct packed {
        logic                     result_kind;
        logic [PIXEL_W-1:0]       pixel;
        logic signed [DATA_W-1:0] frame_min;
        logic signed [DATA_W-1:0] frame_max;
        logic                     none_valid;
        logic                     result_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]               output_mode;
        logic                     nodata_enable;
        logic signed [DATA_W-1:0] nodata_value;
        logic                     limits_enable;
        logic signed [DATA_W-1:0] limit_low;
        logic signed [DATA_W-1:0] limit_high;
    } t_cfg;

    typedef struct packed {
        logic command;
        logic is_void;
        logic frame_last;
    } t_item_tag;

    function automatic logic [RANGE_W-1:0] mode_range(input logic [1:0] mode);
        logic [RANGE_W-1:0] r;
        unique case (mode)
            MODE_8_OFS:  r = 16'd254;
            MODE_8:      r = 16'd255;
            MODE_16_OFS: r = 16'd65534;
            MODE_16:     r = 16'd65535;
            default:     r = 16'd255;
        endcase
        return r;
    endfunction

    function automatic logic [PIXEL_W-1:0] mode_offset(input logic [1:0] mode);
        logic [PIXEL_W-1:0] o;
        unique case (mode)
            MODE_8_OFS, MODE_16_OFS: o = 16'd1;
            MODE_8, MODE_16:         o = 16'd0;
            default:                 o = 16'd0;
        endcase
        return o;
    endfunction

endpackage

>>> sv/mlcs_front.sv
// ---------------------------------------------------------------------------
// mlcs_front
// Accepts items, marks void samples and holds them in a short queue.
// ---------------------------------------------------------------------------
module mlcs_front import mlcs_pkg::*; #(
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  t_in_item                      i_item,
    input  t_cfg                          i_cfg,
    output logic                          o_empty,
    output t_item_tag                     o_tag,
    output logic signed [SAMPLE_WIDTH-1:0] o_x,
    input  logic                          i_pop
);

    localparam int unsigned PTR_W = (MIDQ_DEPTH > 1) ? $clog2(MIDQ_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(MIDQ_DEPTH + 1);

    logic signed [SAMPLE_WIDTH-1:0] x_narrow;
    logic signed [DATA_W-1:0]       x_ext;
    t_item_tag                      tag_in;
    logic                           do_push;
    logic                           do_pop;

    t_item_tag                      r_tag_mem [MIDQ_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_x_mem   [MIDQ_DEPTH];
    logic [PTR_W-1:0]               r_wr_ptr;
    logic [PTR_W-1:0]               r_rd_ptr;
    logic [CNT_W-1:0]               r_count;

    assign x_narrow = i_item.sample[SAMPLE_WIDTH-1:0];
    assign x_ext    = DATA_W'(x_narrow);

    assign tag_in.command    = i_item.command;
    assign tag_in.is_void    = i_item.sample_void ||
                               (i_cfg.nodata_enable && (x_ext == i_cfg.nodata_value));
    assign tag_in.frame_last = i_item.frame_last;

    assign o_full  = (r_count == CNT_W'(MIDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    assign o_tag = r_tag_mem[r_rd_ptr];
    assign o_x   = r_x_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_tag_mem[r_wr_ptr] <= tag_in;
            r_x_mem[r_wr_ptr]   <= x_narrow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/mlcs_div.sv
// ---------------------------------------------------------------------------
// mlcs_div
// Restoring divider for the scale factor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mlcs_div import mlcs_pkg::*; #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RANGE_W-1:0] i_range,
    input  logic [DATA_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [DATA_W-1:0]  o_quotient
);

    localparam int unsigned NUM_W  = RANGE_W + FRACTION_BITS;
    localparam int unsigned STEP_W = $clog2(NUM_W + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [STEP_W-1:0]       r_step;
    logic [NUM_W-1:0]        r_num;
    logic [DATA_W-1:0]       r_rem;
    logic [DATA_W-1:0]       r_div;

    logic [DATA_W:0]         trial;
    logic                    ge;
    logic [DATA_W:0]         trial_sub;
    logic [NUM_W+DATA_W-1:0] q_ext;

    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign ge        = (trial >= {1'b0, r_div});
    assign trial_sub = trial - {1'b0, r_div};

    assign q_ext      = {{DATA_W{1'b0}}, r_num};
    assign o_quotient = (|q_ext[NUM_W+DATA_W-1:DATA_W]) ? '1 : q_ext[DATA_W-1:0];
    assign o_done     = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_range, {FRACTION_BITS{1'b0}}};
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> sv/mlcs_back.sv
// ---------------------------------------------------------------------------
// mlcs_back
// Extremes tracking, scale factor control, pixel pipeline and result queue.
// ---------------------------------------------------------------------------
module mlcs_back import mlcs_pkg::*; #(
    parameter int unsigned SAMPLE_WIDTH  = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_q_empty,
    input  t_item_tag                      i_q_tag,
    input  logic signed [SAMPLE_WIDTH-1:0] i_q_x,
    output logic                           o_q_pop,
    output logic                           o_div_start,
    output logic [RANGE_W-1:0]             o_div_range,
    output logic [DATA_W-1:0]              o_div_divisor,
    input  logic                           i_div_done,
    input  logic [DATA_W-1:0]              i_div_quotient,
    output logic                           o_empty,
    input  logic                           i_pop,
    output t_out_item                      o_result
);

    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned OUT_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam logic [DATA_W-1:0] SCALE_ONE = DATA_W'(1) << FRACTION_BITS;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_CHECK,
        ST_DIVIDE
    } t_state;

    typedef struct packed {
        logic                     kind;
        logic                     last;
        logic                     is_void;
        logic                     pos;
        logic [DATA_W-1:0]        diff;
        logic signed [DATA_W-1:0] fmin;
        logic signed [DATA_W-1:0] fmax;
        logic                     none_valid;
    } t_s1;

    typedef struct packed {
        logic                     kind;
        logic                     last;
        logic                     is_void;
        logic                     pos;
        logic [PROD_W-1:0]        prod;
        logic signed [DATA_W-1:0] fmin;
        logic signed [DATA_W-1:0] fmax;
        logic                     none_valid;
    } t_s2;

    t_state                   r_state;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic                     r_seen;
    logic [DATA_W-1:0]        r_scale;
    logic                     r_restart;
    logic                     r_clamp;

    logic                     r_s1_v;
    t_s1                      r_s1;
    logic                     r_s2_v;
    t_s2                      r_s2;

    t_out_item                r_out_mem [OUTQ_DEPTH];
    logic [OUT_PTR_W-1:0]     r_out_wr;
    logic [OUT_PTR_W-1:0]     r_out_rd;
    logic [OUT_CNT_W-1:0]     r_out_count;

    logic [OUT_CNT_W:0]       in_use;
    logic                     issue;
    logic                     is_measure;
    logic signed [DATA_W-1:0] x_ext;
    logic signed [DATA_W-1:0] cur_min;
    logic signed [DATA_W-1:0] cur_max;
    logic                     cur_seen;
    logic signed [DATA_W-1:0] upd_min;
    logic signed [DATA_W-1:0] upd_max;
    logic                     upd_seen;
    logic signed [DATA_W-1:0] rep_min;
    logic signed [DATA_W-1:0] rep_max;
    logic signed [DATA_W-1:0] x_clamped;
    logic signed [DATA_W:0]   scl_diff;
    logic signed [DATA_W:0]   chk_diff;
    logic                     chk_divide;
    t_s1                      s1_in;

    logic [PROD_W-1:0]        scaled;
    logic [RANGE_W-1:0]       out_range;
    logic [PIXEL_W-1:0]       out_offset;
    logic [PIXEL_W-1:0]       v_sat;
    t_out_item                s2_result;
    logic                     out_pop;

    // ---- issue from the queue -------------------------------------------
    assign in_use = {1'b0, r_out_count} + (OUT_CNT_W+1)'(r_s1_v) + (OUT_CNT_W+1)'(r_s2_v);
    assign issue  = (r_state == ST_RUN) && !i_q_empty &&
                    (in_use < (OUT_CNT_W+1)'(OUTQ_DEPTH));
    assign o_q_pop    = issue;
    assign is_measure = (i_q_tag.command == CMD_MEASURE);

    assign x_ext    = DATA_W'(i_q_x);
    assign cur_min  = r_restart ? SAMPLE_MAX : r_min;
    assign cur_max  = r_restart ? SAMPLE_MIN : r_max;
    assign cur_seen = r_restart ? 1'b0 : r_seen;
    assign upd_min  = (!i_q_tag.is_void && (x_ext < cur_min)) ? x_ext : cur_min;
    assign upd_max  = (!i_q_tag.is_void && (x_ext > cur_max)) ? x_ext : cur_max;
    assign upd_seen = cur_seen || !i_q_tag.is_void;
    assign rep_min  = i_cfg.limits_enable ? i_cfg.limit_low  : upd_min;
    assign rep_max  = i_cfg.limits_enable ? i_cfg.limit_high : upd_max;

    always_comb begin
        x_clamped = x_ext;
        if (r_clamp) begin
            if (x_ext < r_min) begin
                x_clamped = r_min;
            end else if (x_ext > r_max) begin
                x_clamped = r_max;
            end
        end
    end

    assign scl_diff = (DATA_W+1)'(x_clamped) - (DATA_W+1)'(r_min);

    always_comb begin
        s1_in.last       = i_q_tag.frame_last;
        s1_in.is_void    = i_q_tag.is_void;
        s1_in.pos        = !scl_diff[DATA_W] && (|scl_diff[DATA_W-1:0]);
        s1_in.diff       = scl_diff[DATA_W-1:0];
        s1_in.fmin       = rep_min;
        s1_in.fmax       = rep_max;
        s1_in.none_valid = !upd_seen;
        s1_in.kind       = is_measure ? KIND_REPORT : KIND_PIXEL;
    end

    // ---- scale factor check, registered extremes ------------------------
    assign chk_diff      = (DATA_W+1)'(r_max) - (DATA_W+1)'(r_min);
    assign chk_divide    = (r_clamp || r_seen) && (chk_diff > (DATA_W+1)'(0));
    assign o_div_start   = (r_state == ST_CHECK) && chk_divide;
    assign o_div_range   = mode_range(i_cfg.output_mode);
    assign o_div_divisor = chk_diff[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_min     <= SAMPLE_MAX;
            r_max     <= SAMPLE_MIN;
            r_seen    <= 1'b0;
            r_scale   <= SCALE_ONE;
            r_restart <= 1'b0;
            r_clamp   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    if (issue && is_measure) begin
                        r_min     <= upd_min;
                        r_max     <= upd_max;
                        r_seen    <= upd_seen;
                        r_restart <= 1'b0;
                        if (i_q_tag.frame_last) begin
                            r_min     <= rep_min;
                            r_max     <= rep_max;
                            r_clamp   <= i_cfg.limits_enable;
                            r_restart <= 1'b1;
                            r_state   <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (chk_divide) begin
                        r_state <= ST_DIVIDE;
                    end else begin
                        r_scale <= SCALE_ONE;
                        r_state <= ST_RUN;
                    end
                end
                ST_DIVIDE: begin
                    if (i_div_done) begin
                        r_scale <= i_div_quotient;
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    // ---- pixel pipeline --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= issue && (!is_measure || i_q_tag.frame_last);
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1            <= s1_in;
        r_s2.kind       <= r_s1.kind;
        r_s2.last       <= r_s1.last;
        r_s2.is_void    <= r_s1.is_void;
        r_s2.pos        <= r_s1.pos;
        r_s2.prod       <= r_s1.diff * r_scale;
        r_s2.fmin       <= r_s1.fmin;
        r_s2.fmax       <= r_s1.fmax;
        r_s2.none_valid <= r_s1.none_valid;
    end

    assign scaled     = r_s2.prod >> FRACTION_BITS;
    assign out_range  = mode_range(i_cfg.output_mode);
    assign out_offset = mode_offset(i_cfg.output_mode);
    assign v_sat      = (scaled > PROD_W'(out_range)) ? PIXEL_W'(out_range)
                                                      : scaled[PIXEL_W-1:0];

    always_comb begin
        s2_result.result_kind = r_s2.kind;
        if (r_s2.kind == KIND_REPORT) begin
            s2_result.pixel       = '0;
            s2_result.frame_min   = r_s2.fmin;
            s2_result.frame_max   = r_s2.fmax;
            s2_result.none_valid  = r_s2.none_valid;
            s2_result.result_last = 1'b1;
        end else begin
            if (r_s2.is_void) begin
                s2_result.pixel = '0;
            end else begin
                s2_result.pixel = (r_s2.pos ? v_sat : '0) + out_offset;
            end
            s2_result.frame_min   = '0;
            s2_result.frame_max   = '0;
            s2_result.none_valid  = 1'b0;
            s2_result.result_last = r_s2.last;
        end
    end

    // ---- result queue ----------------------------------------------------
    assign o_empty  = (r_out_count == '0);
    assign out_pop  = i_pop && !o_empty;
    assign o_result = r_out_mem[r_out_rd];

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_out_mem[r_out_wr] <= s2_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr    <= '0;
            r_out_rd    <= '0;
            r_out_count <= '0;
        end else begin
            if (r_s2_v) begin
                r_out_wr <= (r_out_wr == OUT_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_out_wr + 1'b1;
            end
            if (out_pop) begin
                r_out_rd <= (r_out_rd == OUT_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_out_rd + 1'b1;
            end
            if (r_s2_v && !out_pop) begin
                r_out_count <= r_out_count + 1'b1;
            end else if (out_pop && !r_s2_v) begin
                r_out_count <= r_out_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/minmax_linear_contrast_stretch_top.sv
// ---------------------------------------------------------------------------
// minmax_linear_contrast_stretch_top
// Min-max linear contrast stretch of signed samples into 8/16-bit pixels.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_item and raise push; a transfer happens when full
//   is low. Each frame is sent twice: a measure pass (command 0) and a scale
//   pass (command 1), each closed by frame_last.
//   Result queue: o_result holds the oldest result while empty is low; pop
//   takes it. The last measure item yields one extremes report; each scale
//   item yields one pixel. Other measure items yield nothing.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   write only while the block is idle.
// Timing:
//   An item passes the input queue, stages s1 and s2 and the result queue.
//   Throughput is one item per cycle while the back end takes items. After a
//   report it stops taking items while the scale factor is formed: a check,
//   then, if max > min, the restoring divider, one quotient bit per cycle.
// Reset: synchronous, active low; both queues empty, registers at defaults.
// Stall: when pop stays low, the 4-entry result queue fills, the back end
//   stops, the 2-entry input queue fills and full rises; nothing is lost.
// ---------------------------------------------------------------------------
module minmax_linear_contrast_stretch_top import mlcs_pkg::*; #(
    parameter int unsigned SAMPLE_WIDTH  = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_item,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_cfg                           r_cfg;

    logic                           q_empty;
    t_item_tag                      q_tag;
    logic signed [SAMPLE_WIDTH-1:0] q_x;
    logic                           q_pop;
    logic                           div_start;
    logic [RANGE_W-1:0]             div_range;
    logic [DATA_W-1:0]              div_divisor;
    logic                           div_done;
    logic [DATA_W-1:0]              div_quotient;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OUTPUT_MODE:   r_cfg.output_mode   <= i_cfg_data[1:0];
                CFG_NODATA_ENABLE: r_cfg.nodata_enable <= i_cfg_data[0];
                CFG_NODATA_VALUE:  r_cfg.nodata_value  <= i_cfg_data;
                CFG_LIMITS_ENABLE: r_cfg.limits_enable <= i_cfg_data[0];
                CFG_LIMIT_LOW:     r_cfg.limit_low     <= i_cfg_data;
                CFG_LIMIT_HIGH:    r_cfg.limit_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mlcs_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_empty (q_empty),
        .o_tag   (q_tag),
        .o_x     (q_x),
        .i_pop   (q_pop)
    );

    mlcs_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_range    (div_range),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    mlcs_back #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .i_q_tag        (q_tag),
        .i_q_x          (q_x),
        .o_q_pop        (q_pop),
        .o_div_start    (div_start),
        .o_div_range    (div_range),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_result       (o_result)
    );

endmodule

>>> sv/mlcs_checker.sv
// ---------------------------------------------------------------------------
// mlcs_checker
// Port-level checks of the contrast stretch result queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlcs_checker import mlcs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    `MLCS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty, "result queue not empty after reset")

    `MLCS_ASSERT(a_report_shape, i_clk, i_rst_n, (!empty && o_result.result_kind == KIND_REPORT) |-> (o_result.result_last && o_result.pixel == '0), "malformed extremes report")

    `MLCS_ASSERT(a_pixel_shape, i_clk, i_rst_n, (!empty && o_result.result_kind == KIND_PIXEL) |-> (o_result.frame_min == '0 && o_result.frame_max == '0 && !o_result.none_valid), "pixel result carries report fields")

    `MLCS_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_result)), "stalled result changed")

endmodule

bind minmax_linear_contrast_stretch_top mlcs_checker u_mlcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

>>> tb/mlcs_stretch_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mlcs_stretch_checker
// Watches the item, result and register channels of the contrast stretch,
// predicts each result from its own copy of the frame state and registers,
// and compares every popped result field by field with the oldest
// prediction. Hands a failure count and the number of waiting results out.
// ---------------------------------------------------------------------------
module mlcs_stretch_checker import mlcs_pkg::*; #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  t_in_item             i_item,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  t_out_item            i_result,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    t_cfg                     regs;
    logic signed [DATA_W-1:0] low_bound;
    logic signed [DATA_W-1:0] high_bound;
    logic                     any_valid;
    logic                     restart_pending;
    logic                     clamp_latched;
    logic [31:0]              scale_fx;
    t_out_item                expected_results[$];
    int                       fails;

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic clear_frame();
        low_bound  = SAMPLE_MAX;
        high_bound = SAMPLE_MIN;
        any_valid  = 1'b0;
    endtask

    task automatic stretch_predict(input t_in_item it);
        t_out_item          r;
        logic               skip;
        longint             x;
        longint             d;
        longint unsigned    rng;
        longint unsigned    ofs;
        longint unsigned    q;
        longint unsigned    v;
        r    = '0;
        skip = it.sample_void || (regs.nodata_enable && it.sample == regs.nodata_value);
        x    = it.sample;
        case (regs.output_mode)
            MODE_8_OFS:  begin rng = 254;   ofs = 1; end
            MODE_8:      begin rng = 255;   ofs = 0; end
            MODE_16_OFS: begin rng = 65534; ofs = 1; end
            default:     begin rng = 65535; ofs = 0; end
        endcase
        if (it.command == CMD_MEASURE) begin
            if (restart_pending) begin
                clear_frame();
                restart_pending = 1'b0;
            end
            if (!skip) begin
                if (x < low_bound) low_bound = it.sample;
                if (x > high_bound) high_bound = it.sample;
                any_valid = 1'b1;
            end
            if (it.frame_last) begin
                clamp_latched = regs.limits_enable;
                if (clamp_latched) begin
                    low_bound  = regs.limit_low;
                    high_bound = regs.limit_high;
                end
                d        = longint'(high_bound) - longint'(low_bound);
                scale_fx = 32'd1 << FRACTION_BITS;
                if ((clamp_latched || any_valid) && d > 0) begin
                    q = (rng << FRACTION_BITS) / longint'(d);
                    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
                    scale_fx = q[31:0];
                end
                restart_pending = 1'b1;
                r.result_kind = KIND_REPORT;
                r.frame_min   = low_bound;
                r.frame_max   = high_bound;
                r.none_valid  = !any_valid;
                r.result_last = 1'b1;
                expected_results.push_back(r);
            end
        end else begin
            r.result_kind = KIND_PIXEL;
            r.result_last = it.frame_last;
            if (!skip) begin
                if (clamp_latched) begin
                    if (x < low_bound) x = low_bound;
                    else if (x > high_bound) x = high_bound;
                end
                d = x - longint'(low_bound);
                v = 0;
                if (d > 0) begin
                    v = (longint'(d) * longint'({32'd0, scale_fx})) >> FRACTION_BITS;
                    if (v > rng) v = rng;
                end
                r.pixel = 16'(v + ofs);
            end
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            regs = '0;
            clear_frame();
            scale_fx        = 32'd1 << FRACTION_BITS;
            restart_pending = 1'b0;
            clamp_latched   = 1'b0;
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $error("result_kind: expected no transfer, got %0d", i_result.result_kind);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.result_kind, i_result.result_kind);
                    check_field("pixel", want.pixel, i_result.pixel);
                    check_field("frame_min", want.frame_min, i_result.frame_min);
                    check_field("frame_max", want.frame_max, i_result.frame_max);
                    check_field("none_valid", want.none_valid, i_result.none_valid);
                    check_field("result_last", want.result_last, i_result.result_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OUTPUT_MODE:   regs.output_mode   = i_cfg_data[1:0];
                    CFG_NODATA_ENABLE: regs.nodata_enable = i_cfg_data[0];
                    CFG_NODATA_VALUE:  regs.nodata_value  = i_cfg_data;
                    CFG_LIMITS_ENABLE: regs.limits_enable = i_cfg_data[0];
                    CFG_LIMIT_LOW:     regs.limit_low     = i_cfg_data;
                    CFG_LIMIT_HIGH:    regs.limit_high    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) stretch_predict(i_item);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/minmax_linear_contrast_stretch_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// minmax_linear_contrast_stretch_top_tb
// Drives measure and scale passes into the contrast stretch: a directed
// set of corner frames, then random frames under changing register
// settings, with sender gaps, receiver stalls and one long receiver
// hold-off. A checker beside the block predicts and compares the results.
// ---------------------------------------------------------------------------
module minmax_linear_contrast_stretch_top_tb;
    import mlcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 1200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    t_in_item             i_item;
    logic                 empty;
    logic                 pop;
    t_out_item            o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_stall_pct;
    bit   hold_req;
    int   hold_left;
    int   quiet_cycles;
    int   item_count;
    t_cfg cfg_now;

    minmax_linear_contrast_stretch_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mlcs_stretch_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        pop       = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop = 1'b0;
            end else begin
                pop = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(input logic cmd, input logic signed [DATA_W-1:0] sample,
                        input logic is_void, input logic last);
        t_in_item it;
        bit       done;
        it.command     = cmd;
        it.sample      = sample;
        it.sample_void = is_void;
        it.frame_last  = last;
        done           = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < tx_idle_pct) begin
                push   = 1'b0;
                i_item = t_in_item'({$urandom, $urandom});
            end else begin
                push   = 1'b1;
                i_item = it;
                @(posedge i_clk);
                done = !full;
            end
        end
        item_count++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic write_cfg(input t_cfg c);
        wait_idle();
        write_reg(CFG_OUTPUT_MODE, 32'(c.output_mode));
        write_reg(CFG_NODATA_ENABLE, 32'(c.nodata_enable));
        write_reg(CFG_NODATA_VALUE, c.nodata_value);
        write_reg(CFG_LIMITS_ENABLE, 32'(c.limits_enable));
        write_reg(CFG_LIMIT_LOW, c.limit_low);
        write_reg(CFG_LIMIT_HIGH, c.limit_high);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_now     = c;
    endtask

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return 32'($urandom_range(0, 2000)) - 32'sd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg                     c;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        c.output_mode   = 2'($urandom_range(0, 3));
        c.nodata_enable = 1'($urandom_range(0, 1));
        c.nodata_value  = random_value();
        c.limits_enable = ($urandom_range(0, 2) == 0);
        a = random_value();
        b = random_value();
        case ($urandom_range(0, 3))
            0: begin c.limit_low = SAMPLE_MIN; c.limit_high = SAMPLE_MAX; end
            1: begin c.limit_low = b; c.limit_high = a; end
            default: begin
                c.limit_low  = (a < b) ? a : b;
                c.limit_high = (a < b) ? b : a;
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] gen_sample(
        input logic signed [DATA_W-1:0] base, input int unsigned spread);
        case ($urandom_range(0, 19))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return cfg_now.nodata_value;
            3:       return $urandom;
            default: return base + 32'($urandom_range(0, spread)) - 32'(spread / 8);
        endcase
    endfunction

    task automatic send_frame();
        int                       n;
        int                       m;
        int unsigned              spread;
        logic signed [DATA_W-1:0] base;
        if ($urandom_range(0, 9) == 0) begin
            // stray items: scale without measure, unfinished passes
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                send(1'($urandom), $urandom, 1'($urandom), 1'($urandom));
        end else begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n + 3) : n;
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = $urandom_range(1, 50);
                2:       spread = $urandom_range(51, 100000);
                default: spread = $urandom;
            endcase
            case ($urandom_range(0, 2))
                0:       base = cfg_now.limit_low;
                1:       base = 32'($urandom_range(0, 2000)) - 32'sd1000;
                default: base = $urandom;
            endcase
            for (int i = 0; i < n; i++)
                send(CMD_MEASURE, gen_sample(base, spread), ($urandom_range(0, 9) == 0),
                     i == n - 1);
            for (int i = 0; i < m; i++)
                send(CMD_SCALE, gen_sample(base, spread), ($urandom_range(0, 9) == 0),
                     i == m - 1);
        end
    endtask

    initial begin
        int target;
        int blk;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_OUTPUT_MODE;
        i_cfg_data   = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        item_count   = 0;
        cfg_now      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // scale items on the reset state
        send(CMD_SCALE, SAMPLE_MAX, 1'b0, 1'b0);
        send(CMD_SCALE, 32'sd0, 1'b1, 1'b1);
        // measure pass with only void samples
        send(CMD_MEASURE, 32'sd9, 1'b1, 1'b1);
        send(CMD_SCALE, 32'sd5, 1'b0, 1'b1);
        // full-scale extremes
        send(CMD_MEASURE, SAMPLE_MIN, 1'b0, 1'b0);
        send(CMD_MEASURE, SAMPLE_MAX, 1'b0, 1'b1);
        send(CMD_SCALE, SAMPLE_MAX, 1'b0, 1'b0);
        send(CMD_SCALE, SAMPLE_MIN, 1'b0, 1'b0);
        send(CMD_SCALE, 32'sd0, 1'b0, 1'b1);
        // equal extremes
        send(CMD_MEASURE, 32'sd7, 1'b0, 1'b0);
        send(CMD_MEASURE, 32'sd7, 1'b0, 1'b1);
        send(CMD_SCALE, 32'sd7, 1'b0, 1'b0);
        send(CMD_SCALE, 32'sd8, 1'b0, 1'b1);
        // limits with clamping and a nodata marker
        write_cfg('{MODE_16, 1'b1, -32'sd1, 1'b1, -32'sd100, 32'sd100});
        send(CMD_MEASURE, -32'sd1, 1'b0, 1'b0);
        send(CMD_MEASURE, 32'sd50, 1'b0, 1'b1);
        send(CMD_SCALE, -32'sd500, 1'b0, 1'b0);
        send(CMD_SCALE, 32'sd500, 1'b0, 1'b0);
        send(CMD_SCALE, -32'sd1, 1'b0, 1'b0);
        send(CMD_SCALE, 32'sd0, 1'b0, 1'b1);
        // limits with high not above low, no valid sample
        write_cfg('{MODE_8, 1'b0, 32'sd0, 1'b1, 32'sd10, 32'sd10});
        send(CMD_MEASURE, 32'sd3, 1'b1, 1'b1);
        send(CMD_SCALE, 32'sd20, 1'b0, 1'b1);

        target = item_count + RANDOM_ITEMS;
        blk    = 0;
        while (item_count < target) begin
            case (blk)
                0:       write_cfg('{MODE_16, 1'b1, SAMPLE_MIN, 1'b1, SAMPLE_MIN, SAMPLE_MAX});
                1:       write_cfg('{MODE_8_OFS, 1'b0, SAMPLE_MAX, 1'b0, SAMPLE_MAX, SAMPLE_MIN});
                default: write_cfg(random_cfg());
            endcase
            case (blk % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 70; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 70; end
                default: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
            endcase
            if (blk == 0) hold_req = 1'b1;
            for (int i = 0; i < 75 && item_count < target; ) begin
                int start;
                start = item_count;
                send_frame();
                i += item_count - start;
            end
            blk++;
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
